@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define HLFD_ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hlfd checker: assertion failed");

// Same-cycle implication from a trigger to a consequence.
`define HLFD_ASSERT_IMP(lbl, clk, rst_n, trig, cons) \
	`HLFD_ASSERT_CLK(lbl, clk, rst_n, (trig) |-> (cons))

// Next-cycle implication from a trigger to a consequence.
`define HLFD_ASSERT_NXT(lbl, clk, rst_n, trig, cons) \
	`HLFD_ASSERT_CLK(lbl, clk, rst_n, (trig) |=> (cons))

`endif

@@ rtl/hlfd_pkg.sv @@
// ----------------------------------------------------------------------------
// hlfd_pkg
// Types and constants of the header/length frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hlfd_pkg;

	typedef logic [7:0] data8_t;

	// Reset values of the header registers.
	localparam data8_t HeaderFirstRst  = 8'h5A;
	localparam data8_t HeaderSecondRst = 8'hA5;

	// Command and two address bytes precede the data part of the body.
	localparam data8_t PreDataBytes = 8'd3;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_SEEK1 = 2'd0,
		PH_SEEK2 = 2'd1,
		PH_LEN   = 2'd2,
		PH_BODY  = 2'd3
	} phase_t;

	// Field kind of an output item.
	typedef enum logic [2:0] {
		KIND_LEN  = 3'd0,
		KIND_CMD  = 3'd1,
		KIND_AHI  = 3'd2,
		KIND_ALO  = 3'd3,
		KIND_DATA = 3'd4
	} kind_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_HEADER_FIRST  = 1'b0,
		REG_HEADER_SECOND = 1'b1
	} reg_idx_t;

	// One result item as it travels between the parser and the output stage.
	typedef struct packed {
		data8_t frame_byte;
		kind_t  field_kind;
		data8_t data_index;
		logic   is_last;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/hlfd_ifs.sv @@
// ----------------------------------------------------------------------------
// hlfd_ifs
// Valid/ready channel interfaces of the deframer: byte input, frame output
// and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

// Received byte channel.
interface hlfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Classified frame byte channel.
interface hlfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [2:0] field_kind;
	logic [7:0] data_index;
	logic       is_last;

	modport source (output valid, output frame_byte, output field_kind,
		output data_index, output is_last, input ready);
	modport sink (input valid, input frame_byte, input field_kind,
		input data_index, input is_last, output ready);
endinterface

// Configuration write channel.
interface hlfd_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/hlfd_parser.sv @@
// ----------------------------------------------------------------------------
// hlfd_parser
// Header hunt and body classification state machine. Works on the byte held
// in the input register and updates its state when that item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire hlfd_pkg::data8_t rx_byte,
	input  wire hlfd_pkg::data8_t header_first,
	input  wire hlfd_pkg::data8_t header_second,
	output logic                  res_valid,
	output hlfd_pkg::result_t     result
);

	hlfd_pkg::phase_t phase_q, phase_d;
	hlfd_pkg::data8_t remaining_q, remaining_d;
	hlfd_pkg::data8_t position_q, position_d;
	logic             body_last;

	// The body ends on the byte that sees at most one byte remaining.
	assign body_last = (remaining_q <= 8'd1);

	// Next-state logic.
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		position_d  = position_q;
		case (phase_q)
			hlfd_pkg::PH_SEEK1: begin
				if (rx_byte == header_first) begin
					phase_d = hlfd_pkg::PH_SEEK2;
				end
			end
			hlfd_pkg::PH_SEEK2: begin
				// A matching second byte wins; a repeated first byte restarts the header.
				if (rx_byte == header_second) begin
					phase_d = hlfd_pkg::PH_LEN;
				end else if (rx_byte == header_first) begin
					phase_d = hlfd_pkg::PH_SEEK2;
				end else begin
					phase_d = hlfd_pkg::PH_SEEK1;
				end
			end
			hlfd_pkg::PH_LEN: begin
				remaining_d = rx_byte;
				position_d  = '0;
				phase_d     = (rx_byte == 8'd0) ? hlfd_pkg::PH_SEEK1 : hlfd_pkg::PH_BODY;
			end
			hlfd_pkg::PH_BODY: begin
				position_d = position_q + 8'd1;
				if (body_last) begin
					remaining_d = '0;
					phase_d     = hlfd_pkg::PH_SEEK1;
				end else begin
					remaining_d = remaining_q - 8'd1;
				end
			end
			default: begin
				phase_d = hlfd_pkg::PH_SEEK1;
			end
		endcase
	end

	// Output logic: the length byte and every body byte give one item.
	always_comb begin
		res_valid         = 1'b0;
		result.frame_byte = rx_byte;
		result.field_kind = hlfd_pkg::KIND_LEN;
		result.data_index = '0;
		result.is_last    = 1'b0;
		case (phase_q)
			hlfd_pkg::PH_LEN: begin
				res_valid      = 1'b1;
				result.is_last = (rx_byte == 8'd0);
			end
			hlfd_pkg::PH_BODY: begin
				res_valid      = 1'b1;
				result.is_last = body_last;
				case (position_q)
					8'd0: result.field_kind = hlfd_pkg::KIND_CMD;
					8'd1: result.field_kind = hlfd_pkg::KIND_AHI;
					8'd2: result.field_kind = hlfd_pkg::KIND_ALO;
					default: begin
						result.field_kind = hlfd_pkg::KIND_DATA;
						result.data_index = position_q - hlfd_pkg::PreDataBytes;
					end
				endcase
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// State registers advance once per consumed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hlfd_pkg::PH_SEEK1;
			remaining_q <= '0;
			position_q  <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			position_q  <= position_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/hlfd_out_stage.sv @@
// ----------------------------------------------------------------------------
// hlfd_out_stage
// Result register toward the frame channel. It loads whenever it is empty or
// its item is being taken, so a new item can follow in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hlfd_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire hlfd_pkg::result_t in_result,
	input  wire logic              ready,
	output logic                   advance,
	output logic                   valid,
	output hlfd_pkg::result_t      result
);

	logic              valid_q;
	hlfd_pkg::result_t result_q;

	// The register may take a new item when it is empty or being drained.
	assign advance = !valid_q || ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			result_q <= in_result;
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ rtl/header_length_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// header_length_frame_deframer_core
// Two-byte-header, length-prefixed byte deframer.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and hunts for the two header
// bytes set in configuration registers 0 and 1 (reset 0x5A, 0xA5). The byte
// after the header is a length L; it and the L body bytes that follow are
// passed on, each tagged as length, command, address high, address low or
// data, with the data position and a last-byte mark. Header bytes give no
// output item. One item is accepted per clock cycle; the item for a byte
// passes through the input register and then the result register on its way
// to the output, and throughput drops only while the output is stalled.
// Configuration writes are taken at any time but are meant for an idle block.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_frame_deframer_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hlfd_byte_if.sink    rx,
	hlfd_frame_if.source frame,
	hlfd_cfg_if.sink     cfg
);

	logic              valid_s1;
	hlfd_pkg::data8_t  rx_byte_s1;
	hlfd_pkg::data8_t  header_first_q;
	hlfd_pkg::data8_t  header_second_q;
	logic              advance;
	logic              step;
	logic              res_valid;
	hlfd_pkg::result_t res;
	logic              out_valid;
	hlfd_pkg::result_t out_res;

	// Configuration registers; writes are always accepted.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= hlfd_pkg::HeaderFirstRst;
			header_second_q <= hlfd_pkg::HeaderSecondRst;
		end else if (cfg.valid) begin
			case (hlfd_pkg::reg_idx_t'(cfg.index))
				hlfd_pkg::REG_HEADER_FIRST:  header_first_q  <= cfg.data;
				hlfd_pkg::REG_HEADER_SECOND: header_second_q <= cfg.data;
				default: begin
					header_first_q <= header_first_q;
				end
			endcase
		end
	end

	// Input register: holds one byte until the parser hands it on.
	assign rx.ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// Header hunt and classification.
	hlfd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (rx_byte_s1),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.res_valid     (res_valid),
		.result        (res)
	);

	// Result register.
	hlfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && res_valid),
		.in_result (res),
		.ready     (frame.ready),
		.advance   (advance),
		.valid     (out_valid),
		.result    (out_res)
	);

	// Output channel.
	assign frame.valid      = out_valid;
	assign frame.frame_byte = out_res.frame_byte;
	assign frame.field_kind = 3'(out_res.field_kind);
	assign frame.data_index = out_res.data_index;
	assign frame.is_last    = out_res.is_last;

endmodule

`default_nettype wire

@@ rtl/hlfd_checker.sv @@
// ----------------------------------------------------------------------------
// hlfd_checker
// Port-level checks of the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hlfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] frame_byte,
	input wire logic [2:0] field_kind,
	input wire logic [7:0] data_index,
	input wire logic       is_last
);

	// A stalled item holds its payload.
	`HLFD_ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({frame_byte, field_kind, data_index, is_last}))

	// Field kind stays within the defined codes.
	`HLFD_ASSERT_IMP(a_kind_range, clk, arst_n, out_valid, field_kind <= 3'(hlfd_pkg::KIND_DATA))

	// Only data bytes carry a data position.
	`HLFD_ASSERT_IMP(a_index_data, clk, arst_n, out_valid && (data_index != 8'd0), field_kind == 3'(hlfd_pkg::KIND_DATA))

	// A length item is the last one exactly when the length is zero.
	`HLFD_ASSERT_IMP(a_len_last, clk, arst_n, out_valid && (field_kind == 3'(hlfd_pkg::KIND_LEN)), is_last == (frame_byte == 8'd0))

endmodule

bind header_length_frame_deframer_core hlfd_checker u_hlfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (frame.valid),
	.out_ready  (frame.ready),
	.frame_byte (frame.frame_byte),
	.field_kind (frame.field_kind),
	.data_index (frame.data_index),
	.is_last    (frame.is_last)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the header/length frame deframer core.
// ----------------------------------------------------------------------------
// A clocked driver offers received bytes from a queue that the stimulus
// process fills, and a clocked monitor takes the classified frame bytes.
// Every accepted byte runs through a local copy of the deframer state machine.
// That copy queues the frame item which the block must return, and the
// monitor compares each returned item field by field with the oldest one.
// The header registers are rewritten between phases while the block is idle.
// The settings cover the reset pair, both extremes and equal header bytes.
// Both sides idle at random. The receiver holds off once for a long stretch
// so that the block backs up into its input.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int HoldCycles   = 300;
	localparam int StallLimit   = 3000;
	localparam int SettleCycles = 4;
	localparam int PhaseItems   = 206;
	localparam int NumPhases    = 6;

	logic clk = 1'b0;
	logic arst_n;

	hlfd_byte_if  rx_ch ();
	hlfd_frame_if frame_ch ();
	hlfd_cfg_if   cfg_ch ();

	header_length_frame_deframer_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.frame  (frame_ch),
		.cfg    (cfg_ch)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting to be offered and frame items the block must still return.
	hlfd_pkg::data8_t  pending_rx[$];
	hlfd_pkg::result_t predicted_frame[$];

	// Local copy of the header registers and of the parser state.
	hlfd_pkg::data8_t hdr_first;
	hlfd_pkg::data8_t hdr_second;
	hlfd_pkg::phase_t parse_phase;
	hlfd_pkg::data8_t body_left;
	hlfd_pkg::data8_t body_pos;

	int  mismatch_count = 0;
	int  src_wait = 0;
	int  sink_wait = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  rx_fast = 1'b0;
	bit  sink_fast = 1'b0;
	int  stall_cycles = 0;
	hlfd_pkg::result_t want;

	// Advances the parser copy by one received byte and queues the frame item
	// that the byte produces, if any.
	function automatic void deframe_byte(input hlfd_pkg::data8_t b);
		hlfd_pkg::result_t item;
		logic              last;
		item.frame_byte = b;
		item.data_index = 8'd0;
		item.field_kind = hlfd_pkg::KIND_LEN;
		item.is_last    = 1'b0;
		case (parse_phase)
			hlfd_pkg::PH_SEEK1: begin
				if (b == hdr_first)
					parse_phase = hlfd_pkg::PH_SEEK2;
			end
			hlfd_pkg::PH_SEEK2: begin
				// The second header byte is checked first; a repeated first
				// header byte keeps the hunt in the second-byte state.
				if (b == hdr_second)
					parse_phase = hlfd_pkg::PH_LEN;
				else if (b != hdr_first)
					parse_phase = hlfd_pkg::PH_SEEK1;
			end
			hlfd_pkg::PH_LEN: begin
				body_left = b;
				body_pos = 8'd0;
				last = (b == 8'd0);
				parse_phase = last ? hlfd_pkg::PH_SEEK1 : hlfd_pkg::PH_BODY;
				item.is_last = last;
				predicted_frame.push_back(item);
			end
			default: begin
				if (body_pos == 8'd0)
					item.field_kind = hlfd_pkg::KIND_CMD;
				else if (body_pos == 8'd1)
					item.field_kind = hlfd_pkg::KIND_AHI;
				else if (body_pos == 8'd2)
					item.field_kind = hlfd_pkg::KIND_ALO;
				else begin
					item.field_kind = hlfd_pkg::KIND_DATA;
					item.data_index = body_pos - hlfd_pkg::PreDataBytes;
				end
				last = (body_left <= 8'd1);
				if (body_left > 8'd0)
					body_left = body_left - 8'd1;
				body_pos = body_pos + 8'd1;
				if (last) begin
					parse_phase = hlfd_pkg::PH_SEEK1;
					body_left = 8'd0;
				end
				item.is_last = last;
				predicted_frame.push_back(item);
			end
		endcase
	endfunction

	function automatic int draw_wait(input bit fast);
		return fast ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_val,
		input logic [7:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name,
				exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// Byte driver: one item per handshake, with a random gap after each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= 8'd0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				deframe_byte(rx_ch.rx_byte);
				if ($urandom_range(0, 63) == 0)
					rx_fast = !rx_fast;
				src_wait = draw_wait(rx_fast);
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (src_wait > 0) begin
					src_wait--;
					rx_ch.valid <= 1'b0;
				end else if (pending_rx.size() > 0) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= pending_rx.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Frame monitor: checks each accepted item and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				if (predicted_frame.size() == 0) begin
					$display("%0t: unexpected frame item: expected none, actual %0h/%0d/%0d/%0b",
						$time, frame_ch.frame_byte, frame_ch.field_kind,
						frame_ch.data_index, frame_ch.is_last);
					mismatch_count++;
				end else begin
					want = predicted_frame.pop_front();
					check_field("frame_byte", want.frame_byte, frame_ch.frame_byte);
					check_field("field_kind", 8'(want.field_kind), 8'(frame_ch.field_kind));
					check_field("data_index", want.data_index, frame_ch.data_index);
					check_field("is_last", 8'(want.is_last), 8'(frame_ch.is_last));
				end
				if ($urandom_range(0, 63) == 0)
					sink_fast = !sink_fast;
				sink_wait = draw_wait(sink_fast);
			end
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				frame_ch.ready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				frame_ch.ready <= 1'b0;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= StallLimit) begin
				$display("%0t: no item moved for %0d cycles", $time, StallLimit);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic push_rx(input hlfd_pkg::data8_t b);
		pending_rx.push_back(b);
	endtask

	// Header, length and a random body that now and then holds header bytes.
	task automatic send_frame(input hlfd_pkg::data8_t len);
		push_rx(hdr_first);
		push_rx(hdr_second);
		push_rx(len);
		for (int i = 0; i < int'(len); i++) begin
			case ($urandom_range(0, 15))
				0:       push_rx(hdr_first);
				1:       push_rx(hdr_second);
				default: push_rx(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// Mostly well-formed frames of small length, mixed with noise and
	// broken headers; a rare frame has any length up to the maximum.
	task automatic send_traffic(input int n_items);
		int               made;
		hlfd_pkg::data8_t len;
		made = 0;
		@(negedge clk);
		while (made < n_items) begin
			case ($urandom_range(0, 9))
				0: begin
					push_rx(hdr_first);
					push_rx(8'($urandom_range(0, 255)));
				end
				1: begin
					push_rx(hdr_first);
				end
				2: begin
					repeat ($urandom_range(1, 3))
						push_rx(8'($urandom_range(0, 255)));
				end
				default: begin
					if ($urandom_range(0, 39) == 0)
						len = 8'($urandom_range(0, 255));
					else
						len = 8'($urandom_range(0, 10));
					send_frame(len);
					made += int'(len) + 1;
				end
			endcase
		end
	endtask

	// Sender pause until every byte is taken and every frame item returned.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_rx.size() != 0 || rx_ch.valid || predicted_frame.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_header_reg(input hlfd_pkg::reg_idx_t idx,
		input hlfd_pkg::data8_t val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == hlfd_pkg::REG_HEADER_FIRST)
			hdr_first = val;
		else
			hdr_second = val;
	endtask

	// Stimulus: reset, directed frames, then one random phase per setting.
	initial begin
		hlfd_pkg::data8_t set_first[NumPhases];
		hlfd_pkg::data8_t set_second[NumPhases];
		hlfd_pkg::data8_t directed[$];

		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = 8'd0;
		frame_ch.ready = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = hlfd_pkg::REG_HEADER_FIRST;
		cfg_ch.data    = 8'd0;
		arst_n         = 1'b0;
		hdr_first      = hlfd_pkg::HeaderFirstRst;
		hdr_second     = hlfd_pkg::HeaderSecondRst;
		parse_phase    = hlfd_pkg::PH_SEEK1;
		body_left      = 8'd0;
		body_pos       = 8'd0;

		set_first[0] = 8'h00; set_second[0] = 8'hFF;
		set_first[1] = 8'hFF; set_second[1] = 8'h00;
		set_first[2] = 8'h77; set_second[2] = 8'h77;
		set_first[3] = 8'h00; set_second[3] = 8'h00;
		set_first[4] = 8'($urandom_range(0, 255));
		set_second[4] = 8'($urandom_range(0, 255));
		set_first[5] = hlfd_pkg::HeaderFirstRst;
		set_second[5] = hlfd_pkg::HeaderSecondRst;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero-length frame, a repeated first header byte before a one-byte
		// body, a bad second byte, and header bytes inside a body.
		directed = '{8'h5A, 8'hA5, 8'h00,
			8'h5A, 8'h5A, 8'hA5, 8'h01, 8'hFF,
			8'h5A, 8'h33, 8'hA5,
			8'h5A, 8'hA5, 8'h05, 8'h5A, 8'hA5, 8'h12, 8'h34, 8'h00};
		@(negedge clk);
		foreach (directed[i])
			push_rx(directed[i]);
		wait_drained();

		for (int p = 0; p < NumPhases; p++) begin
			// Header bytes give no item, so let the pipeline empty out.
			wait_drained();
			repeat (SettleCycles) @(posedge clk);
			write_header_reg(hlfd_pkg::REG_HEADER_FIRST, set_first[p]);
			write_header_reg(hlfd_pkg::REG_HEADER_SECOND, set_second[p]);
			@(negedge clk);
			// Equal header registers: two equal bytes form a header.
			if (set_first[p] == set_second[p]) begin
				push_rx(hdr_first);
				push_rx(hdr_first);
				push_rx(8'd1);
				push_rx(hdr_first);
			end
			// Longest frame while the receiver holds off, so the block backs up.
			if (p == 0) begin
				hold_req = 1'b1;
				send_frame(8'd255);
			end
			send_traffic(PhaseItems / 2);
			wait_drained();
			send_traffic(PhaseItems / 2);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (predicted_frame.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
